### hdl/cgm_pkg.sv
package cgm_pkg;

  localparam int SLIDER_BITS   = 16;
  localparam int CFG_IDX_BITS  = 3;
  localparam int SLIDER_ONE    = 16384;
  localparam int UNITY_SUM     = 163840;  // ten times one, base of the white balance terms

  // bt.709 luma weights in q16, sum is exactly one
  localparam int LUMA_R = 13933;
  localparam int LUMA_G = 46871;
  localparam int LUMA_B = 4732;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_TEMPERATURE,
    REG_TINT,
    REG_BRIGHTNESS,
    REG_CONTRAST,
    REG_SATURATION
  } cfg_reg_t;

  typedef enum logic [2:0] {
    BLD_GAIN,
    BLD_LSUM,
    BLD_DIV,
    BLD_DIAG,
    BLD_SAT,
    BLD_MAT,
    BLD_OFF,
    BLD_DONE
  } bld_state_t;

endpackage

### hdl/cgm_in_if.sv
interface cgm_in_if #(parameter int PIXEL_BITS = 12) ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] red_in;
  logic [PIXEL_BITS-1:0] green_in;
  logic [PIXEL_BITS-1:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in, input ready);
  modport sink (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

### hdl/cgm_out_if.sv
interface cgm_out_if #(parameter int PIXEL_BITS = 12) ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] red_out;
  logic [PIXEL_BITS-1:0] green_out;
  logic [PIXEL_BITS-1:0] blue_out;

  modport source (output valid, output red_out, output green_out, output blue_out, input ready);
  modport sink (input valid, input red_out, input green_out, input blue_out, output ready);
endinterface

### hdl/cgm_cfg_if.sv
interface cgm_cfg_if ();
  logic                             valid;
  logic                             ready;
  logic [cgm_pkg::CFG_IDX_BITS-1:0] index;
  logic [cgm_pkg::SLIDER_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/color_grade_matrix_pixel_top.sv
// color grade of an rgb pixel stream by a 3x3 matrix plus offset built from five q2.14
// sliders (temperature, tint, brightness, contrast, saturation). one pixel per clock
// once the matrix is built, unless the output stalls; a pixel passes the input
// register, nine products, row sums, and round and clamp on its way out. the matrix
// is rebuilt after reset and after every slider write by a sequencer with one
// shared restoring divider; while it runs no pixel is accepted (slider writes are
// always taken). write sliders only while no pixel is in flight.
module color_grade_matrix_pixel_top #(
  parameter int PIXEL_BITS     = 12,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  cgm_in_if.sink     in_pix,
  cgm_out_if.source  out_pix,
  cgm_cfg_if.sink    cfg_wr
);

  localparam int F  = COEF_FRAC_BITS;
  localparam int P  = PIXEL_BITS;
  localparam int MW = F + 6;            // matrix coefficient
  localparam int OW = F + 3;            // offset
  localparam int PW = MW + P + 1;       // coefficient times pixel
  localparam int AW = F + P + 9;        // row accumulator

  logic signed [MW-1:0] mat [3][3];
  logic signed [OW-1:0] off_vec;
  logic                 busy;

  // stage valid bits and per-stage advance
  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;

  logic        [P-1:0]  x_r [3];
  logic signed [PW-1:0] p_r [3][3];
  logic signed [AW-1:0] acc_r [3];
  logic signed [AW-1:0] acc_nxt [3];
  logic        [P-1:0]  y_nxt [3];
  logic        [P-1:0]  y_r [3];
  logic signed [AW-1:0] rnd_v [3];

  cgm_build #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_build (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_wr),
    .busy    (busy),
    .mat     (mat),
    .off_vec (off_vec)
  );

  // each stage moves when its own register is empty or the next one moves
  assign en4 = !v4_r || out_pix.ready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  // no pixels while the matrix is being rebuilt
  assign in_pix.ready = en1 && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_pix.valid && in_pix.ready;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // stage 1: capture the input beat
  always_ff @(posedge clk) begin
    if (en1) begin
      x_r[0] <= in_pix.red_in;
      x_r[1] <= in_pix.green_in;
      x_r[2] <= in_pix.blue_in;
    end
  end

  // stage 2: nine coefficient products
  always_ff @(posedge clk) begin
    if (en2) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          p_r[i][j] <= PW'(mat[i][j]) * $signed(PW'(x_r[j]));
        end
      end
    end
  end

  // stage 3: row sums plus offset scaled to pixel units
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc_nxt[i] = AW'(p_r[i][0]) + AW'(p_r[i][1]) + AW'(p_r[i][2])
                 + (AW'(off_vec) <<< P);
    end
  end

  always_ff @(posedge clk) begin
    if (en3) acc_r <= acc_nxt;
  end

  // stage 4: round half up and clamp; any negative sum clamps to zero
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd_v[i] = (acc_r[i] + (AW'(1) <<< (F - 1))) >>> F;
      if (acc_r[i] < 0) begin
        y_nxt[i] = '0;
      end else if (rnd_v[i] > AW'((1 << P) - 1)) begin
        y_nxt[i] = '1;
      end else begin
        y_nxt[i] = P'(rnd_v[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en4) y_r <= y_nxt;
  end

  assign out_pix.valid     = v4_r;
  assign out_pix.red_out   = y_r[0];
  assign out_pix.green_out = y_r[1];
  assign out_pix.blue_out  = y_r[2];

endmodule

### hdl/cgm_build.sv
module cgm_build #(
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  cgm_cfg_if.sink                          cfg,
  output logic                             busy,
  output logic signed [COEF_FRAC_BITS+5:0] mat [3][3],
  output logic signed [COEF_FRAC_BITS+2:0] off_vec
);

  localparam int F   = COEF_FRAC_BITS;
  localparam int UW  = 20;
  localparam int LW  = 34;
  localparam int NW  = F + 35;
  localparam int RW  = LW + 1;
  localparam int QW  = F + 2;
  localparam int GW  = 31;
  localparam int DW  = F + 4;
  localparam int SW  = F + 4;
  localparam int MW  = F + 6;
  localparam int OW  = F + 3;
  localparam int CW  = $clog2(NW + 1);
  localparam int SSH = 30 - F;
  localparam int ESH = (F >= 14) ? F - 14 : 0;
  localparam int ERS = (F >= 14) ? 0 : 14 - F;
  localparam int ERH = (ERS > 0) ? (1 << (ERS - 1)) : 0;
  localparam int PW  = GW + QW;
  localparam int XW  = SW + DW;
  localparam int YW  = SW + 19;

  logic signed [cgm_pkg::SLIDER_BITS-1:0] sld_r [5];
  logic signed [cgm_pkg::SLIDER_BITS-1:0] wr_val;
  logic                                   wr;

  cgm_pkg::bld_state_t state_r, state_nxt;
  logic [1:0]          j_r, j_nxt;
  logic [1:0]          ri_r, ri_nxt;
  logic [CW-1:0]       dv_cnt_r, dv_cnt_nxt;

  logic        [GW-1:0]  g_r;
  logic        [LW-1:0]  lsum_r;
  logic        [NW-1:0]  num_r;
  logic        [RW-1:0]  rem_r;
  logic        [QW-1:0]  q_r;
  logic        [QW-1:0]  gain_r [3];
  logic signed [DW-1:0]  d_r [3];
  logic signed [SW-1:0]  s_r [3];
  logic signed [SW-1:0]  e_r;
  logic signed [MW-1:0]  mat_r [3][3];
  logic signed [OW-1:0]  off_r;

  logic signed [UW-1:0]  u_sel;
  logic signed [16:0]    luma_sel;
  logic signed [36:0]    lprod;
  logic signed [16:0]    ctp, brp, nsa, nct;
  logic signed [33:0]    gprod;
  logic        [NW-1:0]  num_init;
  logic        [RW-1:0]  rem_sh, rem_sub;
  logic                  ge;
  logic        [QW-1:0]  q_sh;
  logic        [PW-1:0]  dprod;
  logic        [PW-1:0]  dval;
  logic signed [33:0]    sprod, sval;
  logic        [15:0]    ep;
  logic signed [SW-1:0]  eval;
  logic signed [SW-1:0]  sfull;
  logic signed [XW-1:0]  mprod, mval;
  logic signed [SW+1:0]  rs;
  logic signed [YW-1:0]  oprod, oval;

  assign cfg.ready = 1'b1;
  assign wr        = cfg.valid && cfg.ready;
  assign busy      = (state_r != cgm_pkg::BLD_DONE);
  assign mat       = mat_r;
  assign off_vec   = off_r;

  // slider write with saturation to +-1.0
  always_comb begin
    wr_val = $signed(cfg.data);
    if (wr_val > 16'(cgm_pkg::SLIDER_ONE)) begin
      wr_val = 16'(cgm_pkg::SLIDER_ONE);
    end else if (wr_val < -16'(cgm_pkg::SLIDER_ONE)) begin
      wr_val = -16'(cgm_pkg::SLIDER_ONE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 5; k++) sld_r[k] <= '0;
    end else if (wr && cfg.index <= cgm_pkg::CFG_IDX_BITS'(cgm_pkg::REG_SATURATION)) begin
      sld_r[cfg.index] <= wr_val;
    end
  end

  // per-step arithmetic, at most one multiplier used per state
  always_comb begin
    case (j_r)
      2'd0: begin
        u_sel    = UW'(cgm_pkg::UNITY_SUM) + UW'(3) * UW'(sld_r[cgm_pkg::REG_TEMPERATURE]);
        luma_sel = 17'(cgm_pkg::LUMA_R);
      end
      2'd1: begin
        u_sel    = UW'(cgm_pkg::UNITY_SUM) - UW'(2) * UW'(sld_r[cgm_pkg::REG_TINT]);
        luma_sel = 17'(cgm_pkg::LUMA_G);
      end
      default: begin
        u_sel    = UW'(cgm_pkg::UNITY_SUM) - UW'(3) * UW'(sld_r[cgm_pkg::REG_TEMPERATURE]);
        luma_sel = 17'(cgm_pkg::LUMA_B);
      end
    endcase
    lprod = 37'(luma_sel) * 37'(u_sel);

    ctp   = 17'(cgm_pkg::SLIDER_ONE) + 17'(sld_r[cgm_pkg::REG_CONTRAST]);
    brp   = 17'(cgm_pkg::SLIDER_ONE) + 17'(sld_r[cgm_pkg::REG_BRIGHTNESS]);
    gprod = 34'(ctp) * 34'(brp);

    // restoring divider step
    num_init = (NW'(u_sel) << (F + 16)) + NW'(lsum_r >> 1);
    rem_sh   = {rem_r[RW-2:0], num_r[NW-1]};
    ge       = (rem_sh >= RW'(lsum_r));
    rem_sub  = rem_sh - RW'(lsum_r);
    q_sh     = {q_r[QW-2:0], ge};

    dprod = PW'(g_r) * PW'(gain_r[j_r]);
    dval  = (dprod + (PW'(1) << 27)) >> 28;

    nsa   = -17'(sld_r[cgm_pkg::REG_SATURATION]);
    sprod = 34'(nsa) * 34'(luma_sel);
    sval  = (sprod >= 0) ? ((sprod + (34'sd1 <<< (SSH - 1))) >>> SSH)
                         : -(((-sprod) + (34'sd1 <<< (SSH - 1))) >>> SSH);

    ep   = 16'(17'(cgm_pkg::SLIDER_ONE) + 17'(sld_r[cgm_pkg::REG_SATURATION]));
    eval = (F >= 14) ? (SW'(ep) <<< ESH) : SW'((18'(ep) + 18'(ERH)) >> ERS);

    sfull = s_r[j_r] + ((ri_r == j_r) ? e_r : SW'(0));
    mprod = XW'(sfull) * XW'(d_r[j_r]);
    mval  = (mprod >= 0) ? ((mprod + (XW'(1) <<< (F - 1))) >>> F)
                         : -(((-mprod) + (XW'(1) <<< (F - 1))) >>> F);

    nct   = -17'(sld_r[cgm_pkg::REG_CONTRAST]);
    rs    = (SW+2)'(s_r[0]) + (SW+2)'(s_r[1]) + (SW+2)'(s_r[2]) + (SW+2)'(e_r);
    oprod = YW'(nct) * YW'(rs);
    oval  = (oprod >= 0) ? ((oprod + (YW'(1) <<< 14)) >>> 15)
                         : -(((-oprod) + (YW'(1) <<< 14)) >>> 15);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= cgm_pkg::BLD_GAIN;
      j_r      <= '0;
      ri_r     <= '0;
      dv_cnt_r <= '0;
    end else begin
      state_r  <= state_nxt;
      j_r      <= j_nxt;
      ri_r     <= ri_nxt;
      dv_cnt_r <= dv_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    j_nxt      = j_r;
    ri_nxt     = ri_r;
    dv_cnt_nxt = dv_cnt_r;
    case (state_r)
      cgm_pkg::BLD_GAIN: begin
        state_nxt = cgm_pkg::BLD_LSUM;
        j_nxt     = '0;
      end
      cgm_pkg::BLD_LSUM: begin
        if (j_r == 2'd2) begin
          state_nxt  = cgm_pkg::BLD_DIV;
          j_nxt      = '0;
          dv_cnt_nxt = '0;
        end else begin
          j_nxt = j_r + 2'd1;
        end
      end
      cgm_pkg::BLD_DIV: begin
        if (dv_cnt_r == CW'(NW)) begin
          dv_cnt_nxt = '0;
          if (j_r == 2'd2) begin
            state_nxt = cgm_pkg::BLD_DIAG;
            j_nxt     = '0;
          end else begin
            j_nxt = j_r + 2'd1;
          end
        end else begin
          dv_cnt_nxt = dv_cnt_r + CW'(1);
        end
      end
      cgm_pkg::BLD_DIAG: begin
        if (j_r == 2'd2) begin
          state_nxt = cgm_pkg::BLD_SAT;
          j_nxt     = '0;
        end else begin
          j_nxt = j_r + 2'd1;
        end
      end
      cgm_pkg::BLD_SAT: begin
        if (j_r == 2'd2) begin
          state_nxt = cgm_pkg::BLD_MAT;
          j_nxt     = '0;
          ri_nxt    = '0;
        end else begin
          j_nxt = j_r + 2'd1;
        end
      end
      cgm_pkg::BLD_MAT: begin
        if (j_r == 2'd2) begin
          j_nxt = '0;
          if (ri_r == 2'd2) begin
            state_nxt = cgm_pkg::BLD_OFF;
          end else begin
            ri_nxt = ri_r + 2'd1;
          end
        end else begin
          j_nxt = j_r + 2'd1;
        end
      end
      cgm_pkg::BLD_OFF: begin
        state_nxt = cgm_pkg::BLD_DONE;
      end
      default: begin
        state_nxt = cgm_pkg::BLD_DONE;
      end
    endcase
    // a slider write restarts the build
    if (wr) begin
      state_nxt  = cgm_pkg::BLD_GAIN;
      j_nxt      = '0;
      ri_nxt     = '0;
      dv_cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      cgm_pkg::BLD_GAIN: begin
        g_r    <= GW'(gprod);
        lsum_r <= '0;
      end
      cgm_pkg::BLD_LSUM: begin
        lsum_r <= lsum_r + LW'(lprod);
      end
      cgm_pkg::BLD_DIV: begin
        if (dv_cnt_r == '0) begin
          num_r <= num_init;
          rem_r <= '0;
          q_r   <= '0;
        end else begin
          num_r <= num_r << 1;
          rem_r <= ge ? rem_sub : rem_sh;
          q_r   <= q_sh;
          if (dv_cnt_r == CW'(NW)) gain_r[j_r] <= q_sh;
        end
      end
      cgm_pkg::BLD_DIAG: begin
        d_r[j_r] <= $signed(DW'(dval));
      end
      cgm_pkg::BLD_SAT: begin
        s_r[j_r] <= SW'(sval);
        e_r      <= eval;
      end
      cgm_pkg::BLD_MAT: begin
        mat_r[ri_r][j_r] <= MW'(mval);
      end
      cgm_pkg::BLD_OFF: begin
        off_r <= OW'(oval);
      end
      default: begin
      end
    endcase
  end

endmodule

### sim/cgm_grade_sb.sv
class cgm_grade_sb;
  logic [11:0] pend_r[$];
  logic [11:0] pend_g[$];
  logic [11:0] pend_b[$];
  longint      mat[9];
  longint      offs[3];
  int          errors;

  function new();
    errors = 0;
    set_sliders(0, 0, 0, 0, 0);
  endfunction

  static function longint rnd(longint v, int n);
    longint h;
    if (n == 0) return v;
    h = longint'(1) <<< (n - 1);
    if (v >= 0) return (v + h) >>> n;
    return -((-v + h) >>> n);
  endfunction

  // rebuild the grading matrix from clamped slider values
  function void set_sliders(longint t, longint tn, longint br, longint ct, longint sa);
    longint u[3], gain[3], d[3], lw[3], lsum, g, row, v;
    lw[0] = cgm_pkg::LUMA_R;
    lw[1] = cgm_pkg::LUMA_G;
    lw[2] = cgm_pkg::LUMA_B;
    u[0] = cgm_pkg::UNITY_SUM + 3 * t;
    u[1] = cgm_pkg::UNITY_SUM - 2 * tn;
    u[2] = cgm_pkg::UNITY_SUM - 3 * t;
    lsum = lw[0] * u[0] + lw[1] * u[1] + lw[2] * u[2];
    g = (cgm_pkg::SLIDER_ONE + ct) * (cgm_pkg::SLIDER_ONE + br);
    for (int j = 0; j < 3; j++) begin
      gain[j] = (u[j] * (longint'(1) <<< 32) + lsum / 2) / lsum;
      d[j] = rnd(g * gain[j], 28);
    end
    for (int i = 0; i < 3; i++) begin
      row = 0;
      for (int j = 0; j < 3; j++) begin
        v = rnd(-sa * lw[j], 14);
        if (i == j) v += (cgm_pkg::SLIDER_ONE + sa) * 4;
        row += v;
        mat[i*3+j] = rnd(v * d[j], 16);
      end
      offs[i] = rnd(-ct * row, 15);
    end
  endfunction

  function void note_pixel(logic [11:0] r, logic [11:0] g, logic [11:0] b);
    longint x[3], acc, y;
    logic [11:0] res[3];
    x[0] = r;
    x[1] = g;
    x[2] = b;
    for (int i = 0; i < 3; i++) begin
      acc = mat[i*3] * x[0] + mat[i*3+1] * x[1] + mat[i*3+2] * x[2] + offs[i] * 4096;
      y = rnd(acc, 16);
      if (y < 0) y = 0;
      if (y > 4095) y = 4095;
      res[i] = y[11:0];
    end
    pend_r.push_back(res[0]);
    pend_g.push_back(res[1]);
    pend_b.push_back(res[2]);
  endfunction

  function void check_pixel(logic [11:0] r, logic [11:0] g, logic [11:0] b);
    logic [11:0] er, eg, eb;
    if (pend_r.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected output beat %h %h %h", r, g, b);
      return;
    end
    er = pend_r.pop_front();
    eg = pend_g.pop_front();
    eb = pend_b.pop_front();
    if (r !== er || g !== eg || b !== eb) begin
      errors++;
      if (errors <= 10)
        $display("pixel: expected %0d %0d %0d, got %0d %0d %0d", er, eg, eb, r, g, b);
    end
  endfunction

  function int pending();
    return pend_r.size();
  endfunction
endclass

### sim/color_grade_matrix_pixel_top_tb.sv
module color_grade_matrix_pixel_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0;
  logic rst_n = 0;

  cgm_in_if  #(.PIXEL_BITS(12)) in_pix();
  cgm_out_if #(.PIXEL_BITS(12)) out_pix();
  cgm_cfg_if cfg_wr();

  color_grade_matrix_pixel_top dut (
    .clk(clk), .rst_n(rst_n), .in_pix(in_pix), .out_pix(out_pix), .cfg_wr(cfg_wr)
  );

  cgm_grade_sb grade_sb = new();
  // slider shadow, clamped, kept for rebuilding the expected matrix
  longint slider[5];
  // when set, neither side idles
  bit     steady = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // checker samples accepted output beats
  always @(posedge clk) begin
    if (rst_n && out_pix.valid && out_pix.ready)
      grade_sb.check_pixel(out_pix.red_out, out_pix.green_out, out_pix.blue_out);
  end

  // sink side: random back pressure
  always @(posedge clk) begin
    out_pix.ready <= steady || ($urandom_range(99) >= 11);
  end

  // write one slider; index past the list is not stored by the block
  task automatic write_slider(logic [2:0] idx, logic [15:0] val);
    longint v;
    cfg_wr.valid <= 1;
    cfg_wr.index <= idx;
    cfg_wr.data <= val;
    do @(posedge clk); while (!cfg_wr.ready);
    cfg_wr.valid <= 0;
    if (idx < 5) begin
      v = longint'($signed(val));
      if (v > cgm_pkg::SLIDER_ONE) v = cgm_pkg::SLIDER_ONE;
      if (v < -cgm_pkg::SLIDER_ONE) v = -cgm_pkg::SLIDER_ONE;
      slider[idx] = v;
      grade_sb.set_sliders(slider[0], slider[1], slider[2], slider[3], slider[4]);
    end
    @(posedge clk);
  endtask

  // valid stays high after the beat so beats can follow back to back
  task automatic send_pixel(logic [11:0] r, logic [11:0] g, logic [11:0] b);
    // random gap before the beat
    while (!steady && $urandom_range(99) < 11) begin
      in_pix.valid <= 0;
      @(posedge clk);
    end
    in_pix.valid <= 1;
    in_pix.red_in <= r;
    in_pix.green_in <= g;
    in_pix.blue_in <= b;
    do @(posedge clk); while (!in_pix.ready);
    grade_sb.note_pixel(r, g, b);
  endtask

  // idle point: every result in, then a wait with the input idle
  task automatic drain();
    in_pix.valid <= 0;
    while (grade_sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_slider();
    case ($urandom_range(5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'h7fff;   // beyond +1.0, clamps
      3: return 16'h8000;   // beyond -1.0, clamps
      default: return 16'($urandom_range(32768) - 16384);
    endcase
  endfunction

  task automatic rand_pixel();
    logic [11:0] c[3];
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(7))
        0: c[k] = 0;
        1: c[k] = 12'hfff;
        default: c[k] = 12'($urandom);
      endcase
    end
    send_pixel(c[0], c[1], c[2]);
  endtask

  initial begin
    in_pix.valid = 0;
    in_pix.red_in = 0;
    in_pix.green_in = 0;
    in_pix.blue_in = 0;
    cfg_wr.valid = 0;
    cfg_wr.index = cgm_pkg::REG_TEMPERATURE;
    cfg_wr.data = 0;
    for (int i = 0; i < 5; i++) slider[i] = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // identity matrix after reset, field extremes
    send_pixel(0, 0, 0);
    send_pixel(12'hfff, 12'hfff, 12'hfff);
    send_pixel(12'hfff, 0, 0);
    send_pixel(0, 12'hfff, 0);
    send_pixel(0, 0, 12'hfff);
    send_pixel(12'h555, 12'haaa, 12'h800);
    drain();

    // strong brightness and contrast: both clamp directions
    write_slider(cgm_pkg::REG_BRIGHTNESS, 16'sd16384);
    write_slider(cgm_pkg::REG_CONTRAST, 16'sd16384);
    write_slider(cgm_pkg::REG_SATURATION, -16'sd16384);
    write_slider(cgm_pkg::REG_TEMPERATURE, 16'h7fff);
    write_slider(cgm_pkg::REG_TINT, 16'h8000);
    write_slider(3'd5, 16'h1234);   // out of range index
    write_slider(3'd7, 16'hffff);
    send_pixel(12'hfff, 12'hfff, 12'hfff);
    send_pixel(12'h100, 12'h080, 12'h040);
    send_pixel(12'h800, 12'h800, 12'h800);
    send_pixel(0, 0, 0);
    drain();
    write_slider(cgm_pkg::REG_BRIGHTNESS, -16'sd16384);
    write_slider(cgm_pkg::REG_CONTRAST, -16'sd16384);
    write_slider(cgm_pkg::REG_SATURATION, 16'sd16384);
    write_slider(cgm_pkg::REG_TEMPERATURE, -16'sd16384);
    write_slider(cgm_pkg::REG_TINT, 16'sd16384);
    send_pixel(12'hfff, 0, 12'hfff);
    send_pixel(12'h7ff, 12'h800, 12'h001);
    drain();

    // random phases, one of them with no idling at all
    for (int ph = 0; ph < 11; ph++) begin
      for (int i = 0; i < 5; i++)
        if ($urandom_range(2) != 0) write_slider(3'(i), rand_slider());
      if (ph == 4) write_slider(3'($urandom_range(7, 5)), 16'($urandom));
      steady = (ph == 6);
      for (int n = 0; n < 150; n++) begin
        rand_pixel();
        // sender holds off until the pipe is empty
        if (n == 75) begin
          in_pix.valid <= 0;
          while (grade_sb.pending() != 0) @(posedge clk);
        end
      end
      steady = 0;
      drain();
    end

    drain();
    if (grade_sb.errors == 0) begin
      $display("color_grade_matrix_pixel_top: match");
    end else begin
      $display("color_grade_matrix_pixel_top: mismatch");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("color_grade_matrix_pixel_top: mismatch");
    $finish;
  end
endmodule
